>>> sv/mu7d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mu7d_pkg
// shared types, constants and the modified base64 lookup for the decoder
// ----------------------------------------------------------------------------
package mu7d_pkg;

  localparam logic [7:0] AMP_CHAR  = 8'h26;
  localparam logic [7:0] DASH_CHAR = 8'h2d;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    JOB_LIT = 1'b0,
    JOB_CP  = 1'b1
  } mu7d_kind_t;

  // one decoded step: a literal byte or a code point to encode
  typedef struct packed {
    mu7d_kind_t  kind;
    logic [20:0] cp;
  } mu7d_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } mu7d_qstat_t;

  // returns {not_b64, value}
  function automatic logic [6:0] b64_lookup(input logic [7:0] b);
    logic [6:0] r;
    r = 7'h40;
    if (b >= 8'h41 && b <= 8'h5a)      r = {1'b0, 6'(b - 8'h41)};
    else if (b >= 8'h61 && b <= 8'h7a) r = {1'b0, 6'(b - 8'h61 + 8'd26)};
    else if (b >= 8'h30 && b <= 8'h39) r = {1'b0, 6'(b - 8'h30 + 8'd52)};
    else if (b == 8'h2b)               r = {1'b0, 6'd62};
    else if (b == 8'h2c)               r = {1'b0, 6'd63};
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/mu7d_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mu7d channel interfaces
// valid/ready channels for encoded input bytes and decoded output bytes
// ----------------------------------------------------------------------------
interface mu7d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       final_byte;
  modport source (output valid, in_byte, final_byte, input ready);
  modport sink   (input valid, in_byte, final_byte, output ready);
endinterface

interface mu7d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface
`default_nettype wire

>>> sv/mu7d_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mu7d_front
// accepts encoded bytes, tracks mode and base64 bits, pushes decode jobs
// ----------------------------------------------------------------------------
module mu7d_front (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  [7:0]            in_byte,
  input  wire                   in_final,
  input  mu7d_pkg::mu7d_qstat_t q_stat,
  output logic                  push,
  output mu7d_pkg::mu7d_job_t   push_job
);

  logic        run_r,  run_nxt;
  logic        amp_r,  amp_nxt;
  logic [21:0] buf_r,  buf_nxt;
  logic [4:0]  cnt_r,  cnt_nxt;
  logic [20:0] held_r, held_nxt;

  logic        accept;
  logic        run_path;
  logic        lit_path;
  logic [21:0] buf_base;
  logic [4:0]  cnt_base;
  logic [20:0] held_base;
  logic [6:0]  b64;
  logic [21:0] buf_add;
  logic [4:0]  cnt_add;
  logic [4:0]  cnt_rem;
  logic [15:0] unit;
  logic        push_c;
  mu7d_pkg::mu7d_job_t job_c;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    run_nxt   = run_r;
    amp_nxt   = amp_r;
    buf_nxt   = buf_r;
    cnt_nxt   = cnt_r;
    held_nxt  = held_r;
    push_c    = 1'b0;
    job_c     = '{kind: mu7d_pkg::JOB_LIT, cp: {13'd0, in_byte}};
    run_path  = 1'b0;
    lit_path  = 1'b0;
    buf_base  = buf_r;
    cnt_base  = cnt_r;
    held_base = held_r;
    b64       = mu7d_pkg::b64_lookup(in_byte);
    buf_add   = '0;
    cnt_add   = '0;
    cnt_rem   = '0;
    unit      = '0;

    if (amp_r) begin
      amp_nxt = 1'b0;
      if (in_byte == mu7d_pkg::DASH_CHAR) begin
        push_c = 1'b1;
        job_c  = '{kind: mu7d_pkg::JOB_LIT, cp: {13'd0, mu7d_pkg::AMP_CHAR}};
      end else begin
        run_nxt   = 1'b1;
        buf_base  = '0;
        cnt_base  = '0;
        held_base = '0;
        buf_nxt   = '0;
        cnt_nxt   = '0;
        held_nxt  = '0;
        run_path  = 1'b1;
      end
    end else if (run_r) begin
      run_path = 1'b1;
    end else begin
      lit_path = 1'b1;
    end

    if (run_path) begin
      if (b64[6]) begin
        run_nxt = 1'b0;
        if (in_byte != mu7d_pkg::DASH_CHAR) begin
          lit_path = 1'b1;
        end
      end else begin
        buf_add = {buf_base[15:0], b64[5:0]};
        cnt_add = cnt_base + 5'd6;
        if (cnt_add < 5'd16) begin
          buf_nxt = buf_add;
          cnt_nxt = cnt_add;
        end else begin
          cnt_rem = cnt_add - 5'd16;
          unit    = 16'(buf_add >> cnt_rem);
          buf_nxt = buf_add & ((22'd1 << cnt_rem) - 22'd1);
          cnt_nxt = cnt_rem;
          if (unit >= 16'hd800 && unit <= 16'hdbff) begin
            held_nxt = {1'b0, 10'(unit - 16'hd800), 10'd0};
          end else begin
            if (unit >= 16'hdc00 && unit <= 16'hdfff) begin
              held_nxt = held_base + {11'd0, 10'(unit - 16'hdc00)} + 21'h10000;
            end else begin
              held_nxt = {5'd0, unit};
            end
            push_c = 1'b1;
            job_c  = '{kind: mu7d_pkg::JOB_CP, cp: held_nxt};
          end
        end
      end
    end

    if (lit_path) begin
      if (in_byte == mu7d_pkg::AMP_CHAR) begin
        amp_nxt = 1'b1;
      end else begin
        push_c = 1'b1;
        job_c  = '{kind: mu7d_pkg::JOB_LIT, cp: {13'd0, in_byte}};
      end
    end

    if (in_final) begin
      run_nxt  = 1'b0;
      amp_nxt  = 1'b0;
      buf_nxt  = '0;
      cnt_nxt  = '0;
      held_nxt = '0;
    end
  end

  assign push     = accept && push_c;
  assign push_job = job_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      amp_r  <= 1'b0;
      buf_r  <= '0;
      cnt_r  <= '0;
      held_r <= '0;
    end else if (accept) begin
      run_r  <= run_nxt;
      amp_r  <= amp_nxt;
      buf_r  <= buf_nxt;
      cnt_r  <= cnt_nxt;
      held_r <= held_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 5'd15)
    else $error("bit count out of range");
  a_amp_not_run: assert property (@(posedge clk) disable iff (!rst_n) amp_r |-> !run_r)
    else $error("ampersand pending inside a run");
  a_final_reset: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_final |=> !run_r && !amp_r && cnt_r == 5'd0 && held_r == 21'd0)
    else $error("state not cleared after final byte");
`endif

endmodule
`default_nettype wire

>>> sv/mu7d_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mu7d_queue
// short job queue between the front and the back
// ----------------------------------------------------------------------------
module mu7d_queue (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  mu7d_pkg::mu7d_job_t   push_job,
  input  wire                   pop,
  output mu7d_pkg::mu7d_job_t   head,
  output mu7d_pkg::mu7d_qstat_t stat
);

  mu7d_pkg::mu7d_job_t              mem_r [mu7d_pkg::QUEUE_DEPTH];
  logic [mu7d_pkg::QPTR_W-1:0]      wr_r, wr_nxt;
  logic [mu7d_pkg::QPTR_W-1:0]      rd_r, rd_nxt;
  logic [mu7d_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == mu7d_pkg::QCNT_W'(mu7d_pkg::QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head       = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? mu7d_pkg::QPTR_W'(wr_r + 1'b1) : wr_r;
    rd_nxt  = pop  ? mu7d_pkg::QPTR_W'(rd_r + 1'b1) : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = mu7d_pkg::QCNT_W'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = mu7d_pkg::QCNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) stat.full |-> !push)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) stat.empty |-> !pop)
    else $error("pop from empty queue");
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    mu7d_pkg::QPTR_W'(wr_r - rd_r) == mu7d_pkg::QPTR_W'(cnt_r))
    else $error("queue pointers disagree with fill count");
`endif

endmodule
`default_nettype wire

>>> sv/mu7d_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mu7d_back
// turns queued jobs into utf-8 bytes, one byte per cycle while out_ready allows, into an output reg
// ----------------------------------------------------------------------------
module mu7d_back (
  input  wire                   clk,
  input  wire                   rst_n,
  input  mu7d_pkg::mu7d_job_t   head,
  input  mu7d_pkg::mu7d_qstat_t q_stat,
  output logic                  pop,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [7:0]            out_byte,
  output logic                  out_last
);

  logic [1:0] idx_r, idx_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic [7:0] obyte_r;
  logic       olast_r;

  logic [1:0] len_m1;
  logic [1:0] rem;
  logic [7:0] byte_c;
  logic       last_c;
  logic       fire;

  always_comb begin
    if (head.kind == mu7d_pkg::JOB_LIT || head.cp <= 21'h7f) begin
      len_m1 = 2'd0;
    end else if (head.cp <= 21'h7ff) begin
      len_m1 = 2'd1;
    end else if (head.cp <= 21'hffff) begin
      len_m1 = 2'd2;
    end else begin
      len_m1 = 2'd3;
    end
    rem    = len_m1 - idx_r;
    last_c = (idx_r == len_m1);
    if (idx_r == 2'd0) begin
      unique case (len_m1)
        2'd0:    byte_c = head.cp[7:0];
        2'd1:    byte_c = 8'hc0 | {3'd0, head.cp[10:6]};
        2'd2:    byte_c = 8'he0 | {4'd0, head.cp[15:12]};
        default: byte_c = 8'hf0 | {5'd0, head.cp[20:18]};
      endcase
    end else begin
      unique case (rem)
        2'd0:    byte_c = 8'h80 | {2'd0, head.cp[5:0]};
        2'd1:    byte_c = 8'h80 | {2'd0, head.cp[11:6]};
        default: byte_c = 8'h80 | {2'd0, head.cp[17:12]};
      endcase
    end
  end

  assign fire = !q_stat.empty && (!ovalid_r || out_ready);
  assign pop  = fire && last_c;

  always_comb begin
    idx_nxt    = idx_r;
    ovalid_nxt = ovalid_r;
    if (fire) begin
      ovalid_nxt = 1'b1;
      idx_nxt    = last_c ? 2'd0 : 2'(idx_r + 2'd1);
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      idx_r    <= idx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      obyte_r <= byte_c;
      olast_r <= last_c;
    end
  end

  assign out_valid = ovalid_r;
  assign out_byte  = obyte_r;
  assign out_last  = olast_r;

`ifndef SYNTHESIS
  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    !q_stat.empty |-> idx_r <= len_m1)
    else $error("byte index past end of job");
  a_mid_job_head: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != 2'd0 |-> !q_stat.empty)
    else $error("job left the queue before its last byte");
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !last_c |=> idx_r == 2'($past(idx_r) + 2'd1))
    else $error("byte index did not advance");
`endif

endmodule
`default_nettype wire

>>> sv/modified_utf7_to_utf8_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modified_utf7_to_utf8_decoder
// imap modified utf-7 mailbox name bytes in, utf-8 bytes out
// ----------------------------------------------------------------------------
// in_chan carries one encoded byte per request plus final_byte, which marks
// the last byte of a name and returns the decoder to literal mode afterwards.
// out_chan carries zero to four utf-8 bytes per input request; last_of_run is
// set on the last byte that a given input request produced.
// an input byte that yields output is written to the job queue at the
// accepting edge; its first byte then moves into the output register, from
// which the receiver takes it while out_chan.ready is high.
// throughput: one input byte per cycle while the four-entry job queue has
// room; the back end emits one output byte per cycle while the receiver
// keeps out_chan.ready high, and pops a job only with its last byte.
// reset (rst_n low, synchronous) clears decode state, queue and the output
// valid flag. when the receiver holds out_chan.ready low, the output register
// keeps its byte, the queue fills and in_chan.ready drops once it is full.
// ----------------------------------------------------------------------------
module modified_utf7_to_utf8_decoder (
  input  wire        clk,
  input  wire        rst_n,
  mu7d_in_if.sink    in_chan,
  mu7d_out_if.source out_chan
);

  logic                  push;
  logic                  pop;
  mu7d_pkg::mu7d_job_t   push_job;
  mu7d_pkg::mu7d_job_t   head;
  mu7d_pkg::mu7d_qstat_t q_stat;

  mu7d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .in_byte  (in_chan.in_byte),
    .in_final (in_chan.final_byte),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  mu7d_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  mu7d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_byte  (out_chan.out_byte),
    .out_last  (out_chan.last_of_run)
  );

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the modified utf-7 decoder against a behavioral decoder that runs
// beside it; two short directed mailbox names come first, then random names and
// byte noise, driven through four phases of sender idling and receiver stalls
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [7:0] data;
  logic       fin;
} enc_req_t;

class utf8_scoreboard;
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } utf8_exp_t;

  utf8_exp_t   exp_q[$];
  logic [7:0]  step_bytes[$];
  bit          in_run;
  bit          amp_seen;
  logic [21:0] acc_bits;
  logic [4:0]  acc_count;
  logic [20:0] held_cp;
  int unsigned n_requests;
  int unsigned n_checked;
  int unsigned n_errors;

  function new();
    clear_state();
    n_requests = 0;
    n_checked  = 0;
    n_errors   = 0;
  endfunction

  function void clear_state();
    in_run    = 1'b0;
    amp_seen  = 1'b0;
    acc_bits  = '0;
    acc_count = '0;
    held_cp   = '0;
  endfunction

  function void take_literal(logic [7:0] b);
    if (b == mu7d_pkg::AMP_CHAR) begin
      amp_seen = 1'b1;
    end else begin
      step_bytes.push_back(b);
    end
  endfunction

  function void take_run_char(logic [7:0] b);
    logic [6:0]  sextet;
    int unsigned unit;
    int unsigned cp;
    sextet = 7'd64;
    if (b >= "A" && b <= "Z") sextet = 7'(b - "A");
    else if (b >= "a" && b <= "z") sextet = 7'(b - "a" + 26);
    else if (b >= "0" && b <= "9") sextet = 7'(b - "0" + 52);
    else if (b == "+") sextet = 7'd62;
    else if (b == ",") sextet = 7'd63;
    // byte outside the alphabet closes the run
    if (sextet == 7'd64) begin
      in_run = 1'b0;
      if (b != mu7d_pkg::DASH_CHAR) take_literal(b);
      return;
    end
    acc_bits  = {acc_bits[15:0], sextet[5:0]};
    acc_count = acc_count + 5'd6;
    if (acc_count < 5'd16) return;
    acc_count = acc_count - 5'd16;
    unit      = 32'(acc_bits >> acc_count) & 32'hffff;
    acc_bits  = acc_bits & ((22'd1 << acc_count) - 22'd1);
    if (unit >= 32'hd800 && unit <= 32'hdbff) begin
      held_cp = 21'((unit - 32'hd800) << 10);
      return;
    end
    if (unit >= 32'hdc00 && unit <= 32'hdfff) begin
      held_cp = 21'(held_cp + unit - 32'hdc00 + 32'h10000);
    end else begin
      held_cp = 21'(unit);
    end
    cp = held_cp;
    if (cp <= 32'h7f) begin
      step_bytes.push_back(8'(cp));
    end else if (cp <= 32'h7ff) begin
      step_bytes.push_back(8'(32'hc0 | (cp >> 6)));
      step_bytes.push_back(8'(32'h80 | (cp & 32'h3f)));
    end else if (cp <= 32'hffff) begin
      step_bytes.push_back(8'(32'he0 | (cp >> 12)));
      step_bytes.push_back(8'(32'h80 | ((cp >> 6) & 32'h3f)));
      step_bytes.push_back(8'(32'h80 | (cp & 32'h3f)));
    end else begin
      step_bytes.push_back(8'(32'hf0 | (cp >> 18)));
      step_bytes.push_back(8'(32'h80 | ((cp >> 12) & 32'h3f)));
      step_bytes.push_back(8'(32'h80 | ((cp >> 6) & 32'h3f)));
      step_bytes.push_back(8'(32'h80 | (cp & 32'h3f)));
    end
  endfunction

  function void note_request(logic [7:0] b, logic fin);
    n_requests++;
    step_bytes.delete();
    if (amp_seen) begin
      amp_seen = 1'b0;
      if (b == mu7d_pkg::DASH_CHAR) begin
        step_bytes.push_back(mu7d_pkg::AMP_CHAR);
      end else begin
        in_run    = 1'b1;
        acc_bits  = '0;
        acc_count = '0;
        held_cp   = '0;
        take_run_char(b);
      end
    end else if (in_run) begin
      take_run_char(b);
    end else begin
      take_literal(b);
    end
    foreach (step_bytes[i]) begin
      exp_q.push_back('{data: step_bytes[i], last: (i == step_bytes.size() - 1)});
    end
    if (fin) clear_state();
  endfunction

  function void check_result(logic [7:0] b, logic last);
    utf8_exp_t want;
    n_checked++;
    if (exp_q.size() == 0) begin
      n_errors++;
      if (n_errors <= 10) $display("unexpected utf-8 byte %02h last %0b", b, last);
      return;
    end
    want = exp_q.pop_front();
    if (want.data !== b || want.last !== last) begin
      n_errors++;
      if (n_errors <= 10) begin
        $display("utf-8 byte %0d: expected %02h last %0b, got %02h last %0b",
                 n_checked, want.data, want.last, b, last);
      end
    end
  endfunction
endclass

module tb;
  logic clk;
  logic rst_n;

  mu7d_in_if  in_chan();
  mu7d_out_if out_chan();

  modified_utf7_to_utf8_decoder i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  utf8_scoreboard sb;
  enc_req_t       req_q[$];
  int unsigned    n_names = 0;
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        sb.note_request(in_chan.in_byte, in_chan.final_byte);
      end
      if (out_chan.valid && out_chan.ready) begin
        sb.check_result(out_chan.out_byte, out_chan.last_of_run);
      end
    end
  end

  function automatic logic [7:0] b64_char(int unsigned v);
    if (v < 26) return 8'(v + "A");
    if (v < 52) return 8'(v - 26 + "a");
    if (v < 62) return 8'(v - 52 + "0");
    return (v == 62) ? "+" : ",";
  endfunction

  // utf-16 units to modified base64, zero padded to whole characters
  function automatic void encode_units(ref logic [7:0] nm[$], input int unsigned units[$]);
    int unsigned acc;
    int unsigned nbits;
    acc   = 0;
    nbits = 0;
    foreach (units[k]) begin
      acc   = (acc << 16) | units[k];
      nbits += 16;
      while (nbits >= 6) begin
        nbits -= 6;
        nm.push_back(b64_char((acc >> nbits) & 63));
      end
      acc &= (32'd1 << nbits) - 1;
    end
    if (nbits != 0) nm.push_back(b64_char((acc << (6 - nbits)) & 63));
  endfunction

  function automatic void add_req(logic [7:0] b, logic fin);
    req_q.push_back('{data: b, fin: fin});
  endfunction

  function automatic void push_name(logic [7:0] nm[$]);
    foreach (nm[i]) add_req(nm[i], i == nm.size() - 1);
    n_names++;
  endfunction

  function automatic void add_random_name();
    logic [7:0]  nm[$];
    int unsigned units[$];
    logic [7:0]  c;
    int unsigned u;
    int unsigned len;
    // byte noise with stray ampersands, dashes and mid-name final flags
    if ($urandom_range(4) == 0) begin
      len = $urandom_range(6, 1);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(7))
          0, 1:    c = mu7d_pkg::AMP_CHAR;
          2:       c = mu7d_pkg::DASH_CHAR;
          3:       c = b64_char($urandom_range(63));
          default: c = 8'($urandom_range(255));
        endcase
        add_req(c, (i == len - 1) || ($urandom_range(7) == 0));
      end
      n_names++;
      return;
    end
    repeat ($urandom_range(4, 1)) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          do c = 8'($urandom_range(8'h7e, 8'h20)); while (c == mu7d_pkg::AMP_CHAR);
          nm.push_back(c);
        end
        4: begin
          do c = 8'($urandom_range(255)); while (c == mu7d_pkg::AMP_CHAR);
          nm.push_back(c);
        end
        5: begin
          nm.push_back(mu7d_pkg::AMP_CHAR);
          nm.push_back(mu7d_pkg::DASH_CHAR);
        end
        default: begin
          units.delete();
          repeat ($urandom_range(3, 1)) begin
            case ($urandom_range(9))
              0, 1: units.push_back($urandom_range(32'h7f));
              2:    units.push_back($urandom_range(32'h7ff, 32'h80));
              3, 4: begin
                u = $urandom_range(32'hffff, 32'h800);
                if (u >= 32'hd800 && u <= 32'hdfff) u ^= 32'h4000;
                units.push_back(u);
              end
              5, 6: begin
                units.push_back($urandom_range(32'hdbff, 32'hd800));
                units.push_back($urandom_range(32'hdfff, 32'hdc00));
              end
              7:       units.push_back($urandom_range(32'hdfff, 32'hdc00));
              8:       units.push_back($urandom_range(32'hdbff, 32'hd800));
              default: units.push_back($urandom_range(32'hffff));
            endcase
          end
          nm.push_back(mu7d_pkg::AMP_CHAR);
          encode_units(nm, units);
          case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: nm.push_back(mu7d_pkg::DASH_CHAR);
            6, 7: begin
              do c = 8'($urandom_range(255));
              while ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
                     (c >= "0" && c <= "9") || c == "+" || c == "," ||
                     c == mu7d_pkg::AMP_CHAR);
              nm.push_back(c);
            end
            default: ;
          endcase
        end
      endcase
    end
    push_name(nm);
  endfunction

  task automatic send_all();
    int unsigned total;
    total = req_q.size();
    foreach (req_q[i]) begin
      case (i * 4 / total)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 86;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 86;
        end
        default: begin
          send_idle_pct  = 12;
          recv_stall_pct = 12;
        end
      endcase
      while ($urandom_range(99) < send_idle_pct) begin
        in_chan.valid <= 1'b0;
        @(posedge clk);
      end
      in_chan.valid      <= 1'b1;
      in_chan.in_byte    <= req_q[i].data;
      in_chan.final_byte <= req_q[i].fin;
      @(posedge clk);
      while (!in_chan.ready) @(posedge clk);
    end
    in_chan.valid <= 1'b0;
  endtask

  initial begin
    logic [7:0]  nm[$];
    int unsigned units[$];
    sb = new();
    in_chan.valid      <= 1'b0;
    in_chan.in_byte    <= 8'h00;
    in_chan.final_byte <= 1'b0;
    rst_n              <= 1'b0;

    // literal extremes, escaped ampersand, 2- and 4-byte output, a lone low
    // surrogate past 0x10ffff, run closed by a literal, 3-byte output,
    // unfinished high surrogate, ampersand as the final byte
    nm    = {8'h00, 8'hff, mu7d_pkg::AMP_CHAR, mu7d_pkg::DASH_CHAR, mu7d_pkg::AMP_CHAR};
    units = {32'h00e9, 32'hdbff, 32'hdfff, 32'hdfff};
    encode_units(nm, units);
    nm.push_back("!");
    nm.push_back(mu7d_pkg::AMP_CHAR);
    units = {32'h20ac, 32'hd800};
    encode_units(nm, units);
    nm.push_back(mu7d_pkg::DASH_CHAR);
    push_name(nm);
    nm = {mu7d_pkg::AMP_CHAR};
    push_name(nm);

    while (req_q.size() < 310) add_random_name();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_all();
    while (sb.exp_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("%0d encoded bytes in %0d names over four idle/stall phases", sb.n_requests,
             n_names);
    $display("%0d utf-8 bytes checked, %0d mismatches", sb.n_checked, sb.n_errors);
    if (sb.n_errors == 0 && sb.exp_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d utf-8 bytes outstanding", sb.exp_q.size());
    $display("Some tests failed");
    $finish;
  end
endmodule
